### design/ilbmu_pkg.sv
package ilbmu_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANAR_MODE = 1'b1;

   localparam logic [9:0] WIDTH_RESET  = 10'd320;
   localparam logic       PLANAR_RESET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DELIVER,
      ST_ROW_READ,
      ST_ROW_WAIT,
      ST_ROW_EMIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_REPEAT,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic put_byte;
      logic rd_issue;
      logic grp_next;
      logic emit_row;
      logic finish;
   } cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      rem_zero;
      logic      rep_last;
      logic      row_full;
      logic      fill_full;
      logic      fill_nz;
      logic      eob;
      logic      planar;
      logic      plane_last;
      logic      group_last;
      logic      out_free;
   } sts_type;

endpackage

### design/ilbmu_ram.sv
module ilbmu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ilbmu_ctrl.sv
module ilbmu_ctrl import ilbmu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      can_go;
   logic      flush_wait;

   // pass-through packing needs the output register only when a group fills
   assign can_go     = sts.planar || !sts.fill_full || sts.out_free;
   assign flush_wait = sts.eob && !sts.planar && sts.fill_nz && !sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.phase == PH_LITERAL || (sts.phase == PH_REPEAT && !sts.rem_zero)) begin
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DELIVER: begin
            if (can_go) begin
               if (sts.planar && sts.row_full) begin
                  state_in = ST_ROW_READ;
               end else if (sts.rep_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ROW_READ: begin
            if (sts.plane_last) state_in = ST_ROW_WAIT;
         end
         ST_ROW_WAIT: begin
            state_in = ST_ROW_EMIT;
         end
         ST_ROW_EMIT: begin
            if (sts.out_free) state_in = sts.group_last ? ST_FINISH : ST_ROW_READ;
         end
         ST_FINISH: begin
            if (!flush_wait) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:     cmd.capture  = req_valid;
         ST_DECODE:   cmd.decode   = 1'b1;
         ST_DELIVER:  cmd.put_byte = can_go;
         ST_ROW_READ: cmd.rd_issue = 1'b1;
         ST_ROW_EMIT: begin
            cmd.emit_row = sts.out_free;
            cmd.grp_next = sts.out_free && !sts.group_last;
         end
         ST_FINISH:   cmd.finish   = !flush_wait;
         default:     cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/ilbmu_dp.sv
module ilbmu_dp import ilbmu_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_body,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_pixels,
   output logic [3:0]            rsp_pixel_count,
   output logic                  rsp_row_end,
   output logic                  rsp_overrun,
   output logic                  rsp_last
);

   localparam int STORE_LEN = 8 * ((MAX_WIDTH + 7) / 8);
   localparam int ADDR_W    = $clog2(STORE_LEN);
   localparam int POS_W     = $clog2(STORE_LEN + 1);
   localparam int CW        = ((POS_W > 11) ? POS_W : 11) + 1;

   // configuration
   logic [9:0] cfg_width_ff, cfg_width_in;
   logic       cfg_planar_ff, cfg_planar_in;

   // request and decoder state
   logic [7:0]  byte_ff, byte_in;
   logic        eob_ff, eob_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  rep_ff, rep_in;
   logic        tail_nz_ff, tail_nz_in;
   logic        clip_ff, clip_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [55:0] acc_ff, acc_in;
   logic [2:0]  fill_ff, fill_in;

   // row readout
   logic [6:0]        grp_ff, grp_in;
   logic [2:0]        plane_ff, plane_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rd_pending_ff;
   logic [7:0]        plane_buf_ff [8];
   logic [7:0]        rd_data;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_pixels_ff, rsp_pixels_in;
   logic [3:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_row_end_ff, rsp_row_end_in;
   logic        rsp_overrun_ff, rsp_overrun_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_load;

   logic [9:0]  ew;
   logic [7:0]  rb;
   logic [10:0] rowlen;
   logic [3:0]  last_cnt;
   logic        row_full, pos_over, out_free, group_last, pass_last;
   logic [7:0]  rem_dec;
   logic        clip;
   logic        ram_we;
   logic [63:0] row_pix;
   logic [63:0] pix_mask;

   always_comb begin
      ew = cfg_width_ff;
      if (cfg_width_ff == 10'd0) ew = 10'd1;
      if (32'(cfg_width_ff) > MAX_WIDTH) ew = 10'(MAX_WIDTH);
   end

   assign rb         = 8'((11'(ew) + 11'd7) >> 3);
   assign rowlen     = {rb, 3'b000};
   assign last_cnt   = (ew[2:0] == 3'd0) ? 4'd8 : {1'b0, ew[2:0]};
   assign row_full   = (CW'(pos_ff) + CW'(1)) >= CW'(rowlen);
   assign pos_over   = CW'(pos_ff) >= CW'(rowlen);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign group_last = ({1'b0, grp_ff} + 8'd1) == rb;
   // no further group this request: fewer than eight bytes left and no flush
   assign pass_last  = (rep_ff <= 8'd8) && !(eob_ff && rep_ff > 8'd1);
   assign rem_dec    = (rem_ff != 8'd0) ? rem_ff - 8'd1 : 8'd0;
   assign clip       = (rep_ff != 8'd1) || tail_nz_ff;

   // bit k of pixel j comes from plane k, leftmost pixel in the byte's MSB
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         for (int k = 0; k < 8; k++) begin
            row_pix[8*j+k] = plane_buf_ff[k][7-j];
         end
      end
   end

   // zero the pixel slots past the row end
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         pix_mask[8*j +: 8] = (!group_last || 4'(j) < last_cnt) ? 8'hFF : 8'h00;
      end
   end

   always_comb begin
      sts.phase      = phase_ff;
      sts.rem_zero   = (rem_ff == 8'd0);
      sts.rep_last   = (rep_ff == 8'd1);
      sts.row_full   = row_full;
      sts.fill_full  = (fill_ff == 3'd7);
      sts.fill_nz    = (fill_ff != 3'd0);
      sts.eob        = eob_ff;
      sts.planar     = cfg_planar_ff;
      sts.plane_last = (plane_ff == 3'd7);
      sts.group_last = group_last;
      sts.out_free   = out_free;
   end

   always_comb begin
      cfg_width_in   = cfg_width_ff;
      cfg_planar_in  = cfg_planar_ff;
      byte_in        = byte_ff;
      eob_in         = eob_ff;
      phase_in       = phase_ff;
      rem_in         = rem_ff;
      rep_in         = rep_ff;
      tail_nz_in     = tail_nz_ff;
      clip_in        = clip_ff;
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      fill_in        = fill_ff;
      grp_in         = grp_ff;
      plane_in       = plane_ff;
      addr_in        = addr_ff;
      ram_we         = 1'b0;
      rsp_load       = 1'b0;
      rsp_pixels_in  = rsp_pixels_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_overrun_in = rsp_overrun_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH: cfg_width_in  = csr_data;
            REG_PLANAR_MODE: cfg_planar_in = csr_data[0];
            default:         cfg_width_in  = cfg_width_ff;
         endcase
      end

      if (cmd.capture) begin
         byte_in = req_data_byte;
         eob_in  = req_end_of_body;
      end

      if (cmd.decode) begin
         case (phase_ff)
            PH_HEADER: begin
               if (byte_ff < 8'd128) begin
                  phase_in = PH_LITERAL;
                  rem_in   = byte_ff + 8'd1;
               end else if (byte_ff > 8'd128) begin
                  phase_in = PH_REPEAT;
                  rem_in   = 8'(9'd257 - {1'b0, byte_ff});
               end
            end
            PH_LITERAL: begin
               rem_in     = rem_dec;
               phase_in   = (rem_dec != 8'd0) ? PH_LITERAL : PH_HEADER;
               rep_in     = 8'd1;
               tail_nz_in = (rem_dec != 8'd0);
               if (cfg_planar_ff && pos_over) pos_in = '0;
            end
            PH_REPEAT: begin
               rep_in     = rem_ff;
               tail_nz_in = 1'b0;
               phase_in   = PH_HEADER;
               rem_in     = 8'd0;
               if (cfg_planar_ff && pos_over) pos_in = '0;
            end
            default: begin
               rem_in = rem_dec;
               if (rem_dec == 8'd0) phase_in = PH_HEADER;
            end
         endcase
      end

      if (cmd.put_byte) begin
         rep_in = rep_ff - 8'd1;
         if (cfg_planar_ff) begin
            ram_we = 1'b1;
            pos_in = pos_ff + POS_W'(1);
            if (row_full) begin
               // row complete: drop the rest of the run, start the readout
               pos_in   = '0;
               clip_in  = clip;
               grp_in   = '0;
               plane_in = '0;
               addr_in  = '0;
               if (clip && phase_ff == PH_LITERAL) phase_in = PH_DISCARD;
            end
         end else if (fill_ff == 3'd7) begin
            rsp_load       = 1'b1;
            rsp_pixels_in  = {byte_ff, acc_ff};
            rsp_count_in   = 4'd8;
            rsp_row_end_in = 1'b0;
            rsp_overrun_in = 1'b0;
            rsp_last_in    = pass_last;
            acc_in         = '0;
            fill_in        = '0;
         end else begin
            for (int i = 0; i < 7; i++) begin
               if (fill_ff == 3'(i)) acc_in[8*i +: 8] = byte_ff;
            end
            fill_in = fill_ff + 3'd1;
         end
      end

      if (cmd.rd_issue) begin
         plane_in = plane_ff + 3'd1;
         addr_in  = ADDR_W'(CW'(addr_ff) + CW'(rb));
      end

      if (cmd.grp_next) begin
         grp_in   = grp_ff + 7'd1;
         plane_in = '0;
         addr_in  = ADDR_W'(CW'(grp_ff) + CW'(1));
      end

      if (cmd.emit_row) begin
         rsp_load       = 1'b1;
         rsp_pixels_in  = row_pix & pix_mask;
         rsp_count_in   = group_last ? last_cnt : 4'd8;
         rsp_row_end_in = group_last;
         rsp_overrun_in = clip_ff;
         rsp_last_in    = group_last;
      end

      if (cmd.finish && eob_ff) begin
         if (!cfg_planar_ff && fill_ff != 3'd0) begin
            rsp_load       = 1'b1;
            rsp_pixels_in  = {8'd0, acc_ff};
            rsp_count_in   = {1'b0, fill_ff};
            rsp_row_end_in = 1'b0;
            rsp_overrun_in = 1'b0;
            rsp_last_in    = 1'b1;
         end
         phase_in = PH_HEADER;
         rem_in   = 8'd0;
         pos_in   = '0;
         acc_in   = '0;
         fill_in  = '0;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_planar_ff <= PLANAR_RESET;
         phase_ff      <= PH_HEADER;
         rem_ff        <= 8'd0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_planar_ff <= cfg_planar_in;
         phase_ff      <= phase_in;
         rem_ff        <= rem_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         rd_pending_ff <= cmd.rd_issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      eob_ff         <= eob_in;
      rep_ff         <= rep_in;
      tail_nz_ff     <= tail_nz_in;
      clip_ff        <= clip_in;
      grp_ff         <= grp_in;
      plane_ff       <= plane_in;
      addr_ff        <= addr_in;
      rsp_pixels_ff  <= rsp_pixels_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_overrun_ff <= rsp_overrun_in;
      rsp_last_ff    <= rsp_last_in;
      // shift plane bytes in as reads return; plane 0 ends in slot 0
      if (rd_pending_ff) begin
         for (int i = 0; i < 7; i++) begin
            plane_buf_ff[i] <= plane_buf_ff[i+1];
         end
         plane_buf_ff[7] <= rd_data;
      end
   end

   ilbmu_ram #(
      .WIDTH (8),
      .DEPTH (STORE_LEN)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(pos_ff)),
      .wr_data (byte_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixels      = rsp_pixels_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_row_end     = rsp_row_end_ff;
   assign rsp_overrun     = rsp_overrun_ff;
   assign rsp_last        = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("output register loaded while occupied");

   a_write_in_row: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_byte && cfg_planar_ff) |-> (CW'(pos_ff) < CW'(rowlen)))
      else $error("row store write beyond row length");

   a_planes_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_row |-> !rd_pending_ff)
      else $error("group emitted before last plane byte returned");

endmodule

### design/ilbm_body_unpack_to_chunky_unit.sv
// A header byte is decoded and the unit then returns to idle to take the next request.
// A literal byte or a run of copies is delivered byte by byte; in planar mode each is a row
// store write. A completed planar row is read out per group of eight pixels: eight plane reads
// through the row store's single read port, a wait for the read data and one output load.
// Synchronous active-high reset clears the decode phase, run count, row position, pass-through
// group and output valid and restores width 320 and planar mode; the row store is not cleared.
module ilbm_body_unpack_to_chunky_unit import ilbmu_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_body,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_pixels,
   output logic [3:0]            rsp_pixel_count,
   output logic                  rsp_row_end,
   output logic                  rsp_overrun,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ilbmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ilbmu_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_data_byte   (req_data_byte),
      .req_end_of_body (req_end_of_body),
      .csr_we          (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixels      (rsp_pixels),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_row_end     (rsp_row_end),
      .rsp_overrun     (rsp_overrun),
      .rsp_last        (rsp_last)
   );

endmodule

### test/ilbm_body_unpack_to_chunky_unit_tb.sv
`timescale 1ns / 1ps

module ilbm_body_unpack_to_chunky_unit_tb;
   import ilbmu_pkg::*;

   localparam int MAX_W = 512;
   localparam int unsigned REPEAT_BASE = 257;
   localparam logic [7:0] NOOP_HEADER = 8'h80;
   localparam int IDLE_LIMIT = 4000;
   // longest request with no result: a 128-copy run written byte by byte
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [63:0] pixels;
      logic [3:0]  count;
      logic        row_end;
      logic        overrun;
      logic        last;
   } pixel_group_type;

   typedef struct packed {
      logic [7:0]      data;
      logic            eob;
      logic            typed;
      pixel_group_type want;
   } body_row_type;

   typedef struct packed {
      logic [9:0] width;
      logic       planar;
      logic [7:0] quota;
      logic       long_runs;
   } body_phase_type;

   localparam pixel_group_type NO_GROUP = '0;

   // run at width 8, planar: one row is eight plane bytes
   localparam body_row_type DIRECTED_BODY [21] = '{
      '{8'hF9, 1'b0, 1'b0, NO_GROUP},
      '{8'hFF, 1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 1'b1}},
      '{8'hF9, 1'b0, 1'b0, NO_GROUP},
      '{8'h80, 1'b0, 1'b1, '{64'h0000_0000_0000_00FF, 4'd8, 1'b1, 1'b0, 1'b1}},
      '{8'h80, 1'b0, 1'b0, NO_GROUP},
      '{8'h02, 1'b0, 1'b0, NO_GROUP},
      '{8'h00, 1'b0, 1'b0, NO_GROUP},
      '{8'hFF, 1'b0, 1'b0, NO_GROUP},
      '{8'h12, 1'b0, 1'b0, NO_GROUP},
      '{8'hFB, 1'b0, 1'b0, NO_GROUP},
      '{8'h34, 1'b0, 1'b0, NO_GROUP},
      '{8'hFA, 1'b0, 1'b0, NO_GROUP},
      '{8'h56, 1'b0, 1'b0, NO_GROUP},
      '{8'h02, 1'b0, 1'b0, NO_GROUP},
      '{8'hC3, 1'b0, 1'b0, NO_GROUP},
      '{8'h80, 1'b0, 1'b0, NO_GROUP},
      '{8'hFF, 1'b0, 1'b0, NO_GROUP},
      '{8'h81, 1'b0, 1'b0, NO_GROUP},
      '{8'h3C, 1'b0, 1'b1, '{64'h0000_FFFF_FFFF_0000, 4'd8, 1'b1, 1'b1, 1'b1}},
      '{8'h03, 1'b0, 1'b0, NO_GROUP},
      '{8'h22, 1'b1, 1'b0, NO_GROUP}
   };

   localparam body_phase_type PHASES [10] = '{
      '{10'd16,   1'b1, 8'd10, 1'b0},
      '{10'd0,    1'b1, 8'd10, 1'b0},
      '{10'd5,    1'b0, 8'd12, 1'b0},
      '{10'd24,   1'b1, 8'd10, 1'b0},
      '{10'd1023, 1'b1, 8'd12, 1'b1},
      '{10'd13,   1'b0, 8'd10, 1'b0},
      '{10'd512,  1'b1, 8'd12, 1'b1},
      '{10'd9,    1'b1, 8'd10, 1'b0},
      '{10'd1,    1'b1, 8'd8,  1'b0},
      '{10'd40,   1'b0, 8'd10, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = '0;
   logic                  req_end_of_body = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [63:0]           rsp_pixels;
   logic [3:0]            rsp_pixel_count;
   logic                  rsp_row_end;
   logic                  rsp_overrun;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   ilbm_body_unpack_to_chunky_unit #(.MAX_WIDTH(MAX_W)) DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder mirror
   logic [9:0]   cur_width;
   logic         cur_planar;
   phase_type    dec_phase;
   int unsigned  run_left;
   int unsigned  row_fill;
   logic [63:0]  grp_acc;
   int unsigned  grp_fill;
   logic [7:0]   row_bytes [MAX_W];

   pixel_group_type byte_groups[$];
   pixel_group_type pending_groups[$];
   int              errors = 0;
   logic            req_calm = 1'b0;
   logic            rsp_calm = 1'b0;

   function automatic int unsigned eff_width();
      int unsigned w;
      w = cur_width;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic void unpack_row(logic ovr);
      int unsigned w, rb, cnt, x, grp, j, k;
      logic [63:0] pix;
      logic [7:0]  p;
      w = eff_width();
      rb = (w + 7) / 8;
      for (grp = 0; grp * 8 < w; grp++) begin
         cnt = (w - grp * 8 > 8) ? 8 : w - grp * 8;
         pix = '0;
         for (j = 0; j < cnt; j++) begin
            x = grp * 8 + j;
            for (k = 0; k < 8; k++) p[k] = row_bytes[k * rb + x / 8][7 - x % 8];
            pix[8 * j +: 8] = p;
         end
         byte_groups.push_back('{pix, 4'(cnt), (grp + 1) * 8 >= w, ovr, 1'b0});
      end
   endfunction

   // place rep copies of b; tail is what the run still has to come
   function automatic logic store_decoded(logic [7:0] b, int unsigned rep, int unsigned tail);
      int unsigned rowlen, i;
      logic clip;
      if (!cur_planar) begin
         for (i = 0; i < rep; i++) begin
            if (grp_fill >= 7) begin
               byte_groups.push_back('{grp_acc | (64'(b) << 56), 4'd8, 1'b0, 1'b0, 1'b0});
               grp_acc = '0;
               grp_fill = 0;
            end else begin
               grp_acc |= 64'(b) << (8 * grp_fill);
               grp_fill++;
            end
         end
         return 1'b0;
      end
      rowlen = 8 * ((eff_width() + 7) / 8);
      if (row_fill >= rowlen) row_fill = 0;
      for (i = 0; i < rep; i++) begin
         row_bytes[row_fill] = b;
         row_fill++;
         if (row_fill >= rowlen) begin
            clip = (rep - 1 - i) + tail > 0;
            unpack_row(clip);
            row_fill = 0;
            return clip;
         end
      end
      return 1'b0;
   endfunction

   function automatic void decode_body_byte(logic [7:0] b, logic eob);
      logic clip;
      pixel_group_type g;
      byte_groups.delete();
      case (dec_phase)
         PH_HEADER: begin
            if (b < NOOP_HEADER) begin
               dec_phase = PH_LITERAL;
               run_left = b + 1;
            end else if (b > NOOP_HEADER) begin
               dec_phase = PH_REPEAT;
               run_left = REPEAT_BASE - b;
            end
         end
         PH_LITERAL: begin
            if (run_left > 0) run_left--;
            dec_phase = (run_left != 0) ? PH_LITERAL : PH_HEADER;
            clip = store_decoded(b, 1, run_left);
            if (clip && run_left > 0) dec_phase = PH_DISCARD;
         end
         PH_REPEAT: begin
            void'(store_decoded(b, run_left, 0));
            dec_phase = PH_HEADER;
            run_left = 0;
         end
         default: begin
            if (run_left > 0) run_left--;
            if (run_left == 0) dec_phase = PH_HEADER;
         end
      endcase
      if (eob) begin
         // flush a partial pass-through group, drop a partial row
         if (!cur_planar && grp_fill > 0)
            byte_groups.push_back('{grp_acc, 4'(grp_fill), 1'b0, 1'b0, 1'b0});
         dec_phase = PH_HEADER;
         run_left = 0;
         row_fill = 0;
         grp_acc = '0;
         grp_fill = 0;
      end
      if (byte_groups.size() > 0) begin
         g = byte_groups.pop_back();
         g.last = 1'b1;
         byte_groups.push_back(g);
      end
   endfunction

   function automatic logic body_ends();
      return $urandom_range(0, 23) == 0;
   endfunction

   task automatic send_request(input logic [7:0] b, input logic eob,
                               input logic typed = 1'b0, input pixel_group_type want = '0);
      int unsigned roll, gap;
      gap = 0;
      if (!req_calm) begin
         roll = $urandom_range(0, 9);
         gap = roll < 6 ? 0 : roll < 9 ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_body <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_body_byte(b, eob);
      if (typed) pending_groups.push_back(want);
      else foreach (byte_groups[i]) pending_groups.push_back(byte_groups[i]);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_IMAGE_WIDTH) cur_width = val;
      else if (idx == REG_PLANAR_MODE) cur_planar = val[0];
   endtask

   task automatic set_format(input logic [9:0] width, input logic planar);
      write_reg(REG_IMAGE_WIDTH, width);
      write_reg(REG_PLANAR_MODE, CSR_DATA_W'(planar));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // well-formed runs with random content, plus no-op headers and stray bytes
   task automatic random_body(input int unsigned quota, input logic long_runs);
      int unsigned sent, kind, len, i;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 15);
         if (kind < 7) begin
            len = (long_runs || $urandom_range(0, 7) != 0) ? $urandom_range(1, 12)
                                                          : $urandom_range(1, 128);
            // keep the literal within what is left of the quota
            if (len + 1 > quota - sent) len = (quota - sent > 1) ? quota - sent - 1 : 1;
            send_request(8'(len - 1), body_ends());
            for (i = 0; i < len; i++) send_request(8'($urandom), body_ends());
            sent += len + 1;
         end else if (kind < 13) begin
            if (long_runs) len = $urandom_range(100, 128);
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(2, 128);
            else len = $urandom_range(2, 24);
            send_request(8'(REPEAT_BASE - len), body_ends());
            send_request(8'($urandom), body_ends());
            sent += 2;
         end else if (kind == 13) begin
            send_request(NOOP_HEADER, body_ends());
            sent++;
         end else begin
            send_request(8'($urandom), body_ends());
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      int unsigned stall_left;
      int unsigned roll;
      if (reset) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (!rsp_calm) begin
         roll = $urandom_range(0, 9);
         stall_left = roll < 6 ? 0 : roll < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if ($urandom_range(0, 255) == 0) rsp_calm = !rsp_calm;
      rsp_stall <= stall_left > 0;
   end

   always @(posedge clock) begin
      pixel_group_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_groups.size() == 0) begin
            $error("unexpected result: pixels %h count %0d", rsp_pixels, rsp_pixel_count);
            errors++;
         end else begin
            want = pending_groups.pop_front();
            if (rsp_pixels !== want.pixels) begin
               $error("pixels: expected %h, got %h", want.pixels, rsp_pixels);
               errors++;
            end
            if (rsp_pixel_count !== want.count) begin
               $error("pixel_count: expected %0d, got %0d", want.count, rsp_pixel_count);
               errors++;
            end
            if (rsp_row_end !== want.row_end) begin
               $error("row_end: expected %b, got %b", want.row_end, rsp_row_end);
               errors++;
            end
            if (rsp_overrun !== want.overrun) begin
               $error("overrun: expected %b, got %b", want.overrun, rsp_overrun);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int idle_cycles;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** ilbm_body_unpack_to_chunky_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      cur_width = WIDTH_RESET;
      cur_planar = PLANAR_RESET;
      dec_phase = PH_HEADER;
      run_left = 0;
      row_fill = 0;
      grp_acc = '0;
      grp_fill = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_format(10'd8, 1'b1);
      foreach (DIRECTED_BODY[i])
         send_request(DIRECTED_BODY[i].data, DIRECTED_BODY[i].eob,
                      DIRECTED_BODY[i].typed, DIRECTED_BODY[i].want);
      wait_drained();

      // phases end without flushing, so a new width can land mid-row
      foreach (PHASES[p]) begin
         set_format(PHASES[p].width, PHASES[p].planar);
         req_calm = $urandom_range(0, 3) == 0;
         random_body(PHASES[p].quota, PHASES[p].long_runs);
         wait_drained();
      end

      if (errors == 0)
         $display("** ilbm_body_unpack_to_chunky_unit: PASSED **");
      else
         $display("** ilbm_body_unpack_to_chunky_unit: FAILED **");
      $finish;
   end

endmodule
